[hdl/pointer_gesture_recognizer_defines.svh]
// Assertion macros shared by the gesture recogniser modules.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef POINTER_GESTURE_RECOGNIZER_DEFINES_SVH
`define POINTER_GESTURE_RECOGNIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pgr_pkg.sv]
package pgr_pkg;

    // Event kind carried on the input tuser.
    typedef enum logic [1:0] {
        MODE_PRESS   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_MOVE    = 2'd2,
        MODE_TICK    = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP_MS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MAX_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN_DIST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_THRESHOLD = 3'd4;

    // Register values after reset.
    localparam logic [15:0] DOUBLE_TAP_MS_RST  = 16'd400;
    localparam logic [15:0] HOLD_MS_RST        = 16'd500;
    localparam logic [15:0] SWIPE_MAX_MS_RST   = 16'd300;
    localparam logic [11:0] SWIPE_MIN_DIST_RST = 12'd50;
    localparam logic [11:0] DRAG_THRESHOLD_RST = 12'd2;

    // Velocity scale (milliseconds to seconds) and output saturation limits.
    localparam int VEL_SCALE = 1000;
    localparam int VEL_LIM = 22'h3FFFFF;
    localparam int DELTA_LIM = 12'hFFF;
    localparam int VEL_W = 23;
    localparam int DELTA_W = 13;

    // Flags that live for one frame and are cleared by each tick.
    typedef struct packed {
        logic moved;
        logic swipe;
        logic drag_end;
        logic drag_start;
        logic hold;
        logic double_tap;
        logic tap;
    } flags_t;

    // One tick result, tapped in the lowest bit.
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [VEL_W-1:0]   swipe_vy;
        logic signed [VEL_W-1:0]   swipe_vx;
        logic                      moved;
        logic                      swipe_seen;
        logic                      drag_active;
        logic                      drag_ended;
        logic                      drag_started;
        logic                      hold_seen;
        logic                      double_tapped;
        logic                      tapped;
    } result_t;

    localparam int OUT_TDATA_W = $bits(result_t);

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic apply;
        logic div_start;
        logic vel_load;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick;
        logic out_free;
        logic need_div;
        logic div_done;
    } status_t;

endpackage

[hdl/pgr_div.sv]
// Restoring divider: one quotient bit per cycle, most significant first.
module pgr_div
    import pgr_pkg::*;
#(
    parameter int N_W = 22
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [31:0]    divisor,
    output logic           busy,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [31:0]    rem_reg, rem_next;
    logic [N_W-1:0] quo_reg, quo_next;
    logic [31:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [32:0]    trial;
    logic [32:0]    diff;
    logic           fits;

    // One trial subtraction per step; the dividend shifts out as quotient bits shift in.
    always_comb begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[31:0] : trial[31:0];
            quo_next = {quo_reg[N_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/pgr_datapath.sv]
`include "pointer_gesture_recognizer_defines.svh"

// Gesture state, configuration registers, distance and time arithmetic,
// velocity dividers and the result register.
module pgr_datapath
    import pgr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                status,
    input  mode_t                  in_mode,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  logic [31:0]            in_time,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   m_ready,
    output logic                   m_valid,
    output result_t                m_result
);

    localparam int C    = COORD_BITS;
    localparam int NW   = C + 10;
    localparam int CW   = (2 * C + 1 > 24) ? 2 * C + 1 : 24;
    localparam int VW   = (NW > 22) ? NW : 22;
    localparam int DW   = (C + 1 > DELTA_W) ? C + 1 : DELTA_W;
    localparam logic [VW-1:0] VLIM = VW'(VEL_LIM);
    localparam logic signed [DW-1:0] DLIM = DW'(DELTA_LIM);

    // Configuration registers.
    logic [15:0] dtap_ms_reg, hold_ms_reg, swipe_max_reg;
    logic [11:0] swipe_min_reg, drag_th_reg;

    // Captured input beat.
    mode_t          mode_reg;
    logic [C-1:0]   in_x_reg, in_y_reg;
    logic [31:0]    in_t_reg;

    // Gesture state.
    logic           down_reg, down_next;
    logic           drag_reg, drag_next;
    logic           tap_valid_reg, tap_valid_next;
    flags_t         flags_reg, flags_next;
    logic [C-1:0]   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [C-1:0]   prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [C-1:0]   start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic [31:0]    press_t_reg, press_t_next, tap_t_reg, tap_t_next;
    logic signed [VEL_W-1:0] vel_x_reg, vel_x_next, vel_y_reg, vel_y_next;

    // Preparation stage.
    logic [C-1:0]   pt_x, pt_y;
    logic [C:0]     dx, dy;
    logic [C-1:0]   adx, ady;
    logic [2*C-1:0] sq_x_reg, sq_y_reg;
    logic [23:0]    th2_reg, sm2_reg;
    logic [NW-1:0]  prod_x_reg, prod_y_reg;
    logic           neg_x_reg, neg_y_reg;
    logic [31:0]    el_reg, gap_reg;

    // Decision stage.
    logic [CW-1:0]  d2;
    logic           over_th, under_th, far_enough;
    logic           el_lt_hold, el_le_swipe, gap_ok;
    logic           is_tick;

    // Result register and dividers.
    result_t        res_reg, res_next;
    logic           m_valid_reg;
    logic           load_res;
    logic [NW-1:0]  q_x, q_y;
    logic           busy_x, busy_y, done_x, done_y;

    // Saturate a quotient magnitude and apply the displacement sign.
    function automatic logic signed [VEL_W-1:0] vel_fix(input logic [NW-1:0] q,
                                                       input logic neg);
        logic [VW-1:0] ext;
        logic [21:0]   mag;
        ext = VW'(q);
        mag = (ext > VLIM) ? 22'(VLIM) : ext[21:0];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // Saturate a position difference to the delta field.
    function automatic logic signed [DELTA_W-1:0] delta_fix(input logic [C:0] diff);
        logic signed [DW-1:0] ext;
        logic signed [DW-1:0] sat;
        ext = DW'($signed(diff));
        if (ext > DLIM) begin
            sat = DLIM;
        end else if (ext < -DLIM) begin
            sat = -DLIM;
        end else begin
            sat = ext;
        end
        return sat[DELTA_W-1:0];
    endfunction

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dtap_ms_reg   <= DOUBLE_TAP_MS_RST;
            hold_ms_reg   <= HOLD_MS_RST;
            swipe_max_reg <= SWIPE_MAX_MS_RST;
            swipe_min_reg <= SWIPE_MIN_DIST_RST;
            drag_th_reg   <= DRAG_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DOUBLE_TAP_MS:  dtap_ms_reg   <= cfg_wdata[15:0];
                REG_HOLD_MS:        hold_ms_reg   <= cfg_wdata[15:0];
                REG_SWIPE_MAX_MS:   swipe_max_reg <= cfg_wdata[15:0];
                REG_SWIPE_MIN_DIST: swipe_min_reg <= cfg_wdata[11:0];
                REG_DRAG_THRESHOLD: drag_th_reg   <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted beat.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= in_mode;
            in_x_reg <= in_x;
            in_y_reg <= in_y;
            in_t_reg <= in_time;
        end
    end

    assign is_tick = (mode_reg == MODE_TICK);

    // Distance point is the current position on a tick, the event position otherwise.
    always_comb begin
        pt_x = is_tick ? cur_x_reg : in_x_reg;
        pt_y = is_tick ? cur_y_reg : in_y_reg;
        dx   = {1'b0, pt_x} - {1'b0, start_x_reg};
        dy   = {1'b0, pt_y} - {1'b0, start_y_reg};
        adx  = dx[C] ? C'(-dx) : dx[C-1:0];
        ady  = dy[C] ? C'(-dy) : dy[C-1:0];
    end

    // Squares, scaled displacements and elapsed times, registered.
    always_ff @(posedge aclk) begin
        sq_x_reg   <= adx * adx;
        sq_y_reg   <= ady * ady;
        th2_reg    <= drag_th_reg * drag_th_reg;
        sm2_reg    <= swipe_min_reg * swipe_min_reg;
        prod_x_reg <= NW'(adx) * NW'(VEL_SCALE);
        prod_y_reg <= NW'(ady) * NW'(VEL_SCALE);
        neg_x_reg  <= dx[C];
        neg_y_reg  <= dy[C];
        el_reg     <= in_t_reg - press_t_reg;
        gap_reg    <= in_t_reg - tap_t_reg;
    end

    // Comparisons for the decision stage.
    always_comb begin
        d2          = CW'(sq_x_reg) + CW'(sq_y_reg);
        over_th     = d2 > CW'(th2_reg);
        under_th    = d2 < CW'(th2_reg);
        far_enough  = d2 >= CW'(sm2_reg);
        el_lt_hold  = el_reg < {16'b0, hold_ms_reg};
        el_le_swipe = el_reg <= {16'b0, swipe_max_reg};
        gap_ok      = gap_reg <= {16'b0, dtap_ms_reg};
    end

    // Event handling and result assembly.
    always_comb begin
        down_next      = down_reg;
        drag_next      = drag_reg;
        tap_valid_next = tap_valid_reg;
        flags_next     = flags_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        press_t_next   = press_t_reg;
        tap_t_next     = tap_t_reg;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        res_next       = res_reg;
        load_res       = 1'b0;

        if (cmd.apply) begin
            unique case (mode_reg)
                MODE_PRESS: begin
                    if (tap_valid_reg && gap_ok) begin
                        flags_next.double_tap = 1'b1;
                    end
                    down_next    = 1'b1;
                    press_t_next = in_t_reg;
                    start_x_next = in_x_reg;
                    start_y_next = in_y_reg;
                    prev_x_next  = cur_x_reg;
                    prev_y_next  = cur_y_reg;
                    cur_x_next   = in_x_reg;
                    cur_y_next   = in_y_reg;
                end
                MODE_RELEASE: begin
                    down_next   = 1'b0;
                    cur_x_next  = in_x_reg;
                    cur_y_next  = in_y_reg;
                    prev_x_next = in_x_reg;
                    prev_y_next = in_y_reg;
                    if (!drag_reg && !flags_reg.hold && under_th && el_lt_hold) begin
                        flags_next.tap = 1'b1;
                        tap_t_next     = in_t_reg;
                        tap_valid_next = 1'b1;
                    end
                    if (far_enough && el_le_swipe) begin
                        flags_next.swipe = 1'b1;
                    end
                    if (drag_reg) begin
                        drag_next           = 1'b0;
                        flags_next.drag_end = 1'b1;
                    end
                end
                MODE_MOVE: begin
                    prev_x_next      = cur_x_reg;
                    prev_y_next      = cur_y_reg;
                    cur_x_next       = in_x_reg;
                    cur_y_next       = in_y_reg;
                    flags_next.moved = 1'b1;
                    if (down_reg && !drag_reg && over_th) begin
                        drag_next             = 1'b1;
                        flags_next.drag_start = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (!drag_reg || !flags_reg.moved) begin
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                    end
                    if (down_reg && !drag_reg && !flags_reg.hold && !el_lt_hold) begin
                        flags_next.hold = 1'b1;
                    end
                    if (down_reg && !drag_reg && over_th) begin
                        drag_next             = 1'b1;
                        flags_next.drag_start = 1'b1;
                    end
                    res_next.tapped        = flags_next.tap;
                    res_next.double_tapped = flags_next.double_tap;
                    res_next.hold_seen     = flags_next.hold;
                    res_next.drag_started  = flags_next.drag_start;
                    res_next.drag_ended    = flags_next.drag_end;
                    res_next.drag_active   = drag_next;
                    res_next.swipe_seen    = flags_next.swipe;
                    res_next.moved         = flags_next.moved;
                    res_next.swipe_vx      = vel_x_reg;
                    res_next.swipe_vy      = vel_y_reg;
                    res_next.delta_x       = delta_fix({1'b0, cur_x_reg} - {1'b0, prev_x_next});
                    res_next.delta_y       = delta_fix({1'b0, cur_y_reg} - {1'b0, prev_y_next});
                    load_res               = 1'b1;
                    flags_next             = '0;
                    vel_x_next             = '0;
                    vel_y_next             = '0;
                end
                default: ;
            endcase
        end

        if (cmd.vel_load) begin
            vel_x_next = vel_fix(q_x, neg_x_reg);
            vel_y_next = vel_fix(q_y, neg_y_reg);
        end
    end

    // Gesture state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg      <= 1'b0;
            drag_reg      <= 1'b0;
            tap_valid_reg <= 1'b0;
            flags_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            press_t_reg   <= '0;
            tap_t_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
        end else begin
            down_reg      <= down_next;
            drag_reg      <= drag_next;
            tap_valid_reg <= tap_valid_next;
            flags_reg     <= flags_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            press_t_reg   <= press_t_next;
            tap_t_reg     <= tap_t_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
        end
    end

    // Output register: a new result may replace one taken in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_res) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    // Velocity dividers, one per axis, both fed the elapsed time.
    pgr_div #(.N_W(NW)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_x_reg),
        .divisor  (el_reg),
        .busy     (busy_x),
        .done     (done_x),
        .quotient (q_x)
    );

    pgr_div #(.N_W(NW)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_y_reg),
        .divisor  (el_reg),
        .busy     (busy_y),
        .done     (done_y),
        .quotient (q_y)
    );

    // Status back to the controller.
    always_comb begin
        status.is_tick  = is_tick;
        status.out_free = !m_valid_reg || m_ready;
        status.need_div = (mode_reg == MODE_RELEASE) && far_enough && el_le_swipe &&
                          (el_reg != 32'd0);
        status.div_done = done_x && done_y;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

    // A drag can only exist while the pointer is down.
    `PGR_ASSERT_SAME(a_drag_needs_down, drag_reg, down_reg, "drag without pointer down")
    // A tick result is never written over one that is still waiting.
    `PGR_ASSERT_SAME(a_res_free, load_res, status.out_free, "result overwritten")
    // The frame flags are empty after every tick.
    `PGR_ASSERT_NEXT(a_tick_clears, load_res, flags_reg == '0, "frame flags not cleared")
    // The dividers run in lock step.
    `PGR_ASSERT_SAME(a_div_lockstep, 1'b1, busy_x == busy_y, "dividers out of step")

endmodule

[hdl/pgr_ctrl.sv]
`include "pointer_gesture_recognizer_defines.svh"

// Sequencer: accept a beat, prepare, apply, and wait for the dividers on a swipe.
module pgr_ctrl
    import pgr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREP   = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_DIVIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // A tick waits here until the output register can take its result.
                if (!status.is_tick || status.out_free) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply     = 1'b1;
                cmd.div_start = status.need_div;
                state_next    = status.need_div ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    cmd.vel_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted beat always moves on to preparation.
    `PGR_ASSERT_NEXT(a_accept_prep, s_valid && s_ready, state_reg == ST_PREP, "beat not prepared")
    // Divider completion is only seen while waiting for it.
    `PGR_ASSERT_SAME(a_done_in_div, status.div_done, state_reg == ST_DIVIDE, "stray divider done")
    // A swipe that starts the dividers parks the sequencer until they finish.
    `PGR_ASSERT_NEXT(a_start_div, cmd.div_start, state_reg == ST_DIVIDE, "divide not awaited")

endmodule

[hdl/pointer_gesture_recognizer.sv]
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   pos_x, pos_y, time_ms, zero padding         mode
// m_axis    out  8 flags, swipe_vx, swipe_vy, delta_x, delta_y  -
// cfg       in   cfg_we, cfg_index, cfg_wdata (write only)
//
// Each beat passes through the idle, preparation and apply states; a tick may wait
// in preparation until the output register is free. A swipe release also waits for
// the bit-serial velocity dividers (one quotient bit a cycle, COORD_BITS + 10 bits).
// One beat is in work at a time; a waiting result does not stop non-tick beats.
// Reset is synchronous and active low and needs no clearing pass.
module pointer_gesture_recognizer
    import pgr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, time_ms, zero padding
    input  logic [((2 * COORD_BITS + 32 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // mode
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tapped, double_tapped, hold_seen, drag_started, drag_ended, drag_active,
    // swipe_seen, moved, swipe_vx, swipe_vy, delta_x, delta_y
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int C = COORD_BITS;

    cmd_t    cmd;
    status_t status;
    result_t result;

    pgr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    pgr_datapath #(.COORD_BITS(C)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (mode_t'(s_axis_tuser)),
        .in_x      (s_axis_tdata[C-1:0]),
        .in_y      (s_axis_tdata[2*C-1:C]),
        .in_time   (s_axis_tdata[2*C+31:2*C]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_result  (result)
    );

    assign m_axis_tdata = result;

endmodule

[test/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgr_pkg::*;

    localparam int S_TDATA_W = ((2 * 12 + 32 + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_PRINTED = 200;

    // Clock, reset and the ports of the block.
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // pos_x, pos_y, time_ms, zero padding
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    // mode
    logic [1:0]             s_axis_tuser = MODE_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tapped, double_tapped, hold_seen, drag_started, drag_ended, drag_active,
    // swipe_seen, moved, swipe_vx, swipe_vy, delta_x, delta_y
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_DOUBLE_TAP_MS;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    pointer_gesture_recognizer #(.COORD_BITS(12)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [15:0] dbl_tap_ms, hold_ms_c, swipe_ms_c;
    logic [11:0] swipe_dist_c, drag_th_c;

    // Shadow copy of the recogniser state.
    logic        down, drg, tap_ok;
    flags_t      fl;
    int          cx, cy, px, py, sx, sy;
    logic [31:0] press_t, tap_t;
    longint      vx, vy;

    // Frame reports still owed by the block, oldest first.
    result_t frame_reports_q [$];

    int    n_err, n_items, n_checked, n_settings;
    int    n_taps, n_dtaps, n_holds, n_drags, n_swipes;
    int    quiet_cycles;
    logic [31:0] now;
    bit    no_idle;
    bit    rx_hold_req;

    string field_names [0:11] = '{"tapped", "double_tapped", "hold_seen", "drag_started",
                                  "drag_ended", "drag_active", "swipe_seen", "moved",
                                  "swipe_vx", "swipe_vy", "delta_x", "delta_y"};

    task automatic report_error(input string msg);
        if (n_err < MAX_PRINTED)
            $display("tb: mismatch at %0t: %s", $time, msg);
        n_err++;
    endtask

    function automatic void model_reset();
        dbl_tap_ms = DOUBLE_TAP_MS_RST;
        hold_ms_c = HOLD_MS_RST;
        swipe_ms_c = SWIPE_MAX_MS_RST;
        swipe_dist_c = SWIPE_MIN_DIST_RST;
        drag_th_c = DRAG_THRESHOLD_RST;
        down = 1'b0;
        drg = 1'b0;
        tap_ok = 1'b0;
        fl = '0;
        cx = 0; cy = 0; px = 0; py = 0; sx = 0; sy = 0;
        press_t = '0;
        tap_t = '0;
        vx = 0;
        vy = 0;
    endfunction

    function automatic longint dist_sq(input int x, input int y);
        longint dx, dy;
        dx = longint'(x) - longint'(sx);
        dy = longint'(y) - longint'(sy);
        return dx * dx + dy * dy;
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // A held pointer that has wandered past the threshold becomes a drag.
    function automatic void check_drag_start();
        longint th;
        th = longint'(drag_th_c);
        if (down && !drg && dist_sq(cx, cy) > th * th) begin
            drg = 1'b1;
            fl.drag_start = 1'b1;
        end
    endfunction

    // Advance the shadow state by one event; a tick yields a frame report.
    function automatic void recognise_event(input mode_t md, input logic [11:0] x,
                                            input logic [11:0] y, input logic [31:0] t,
                                            output bit has_res, output result_t res);
        logic [31:0] el;
        longint d2, th2, sm2;
        has_res = 1'b0;
        res = '0;
        th2 = longint'(drag_th_c) * longint'(drag_th_c);
        sm2 = longint'(swipe_dist_c) * longint'(swipe_dist_c);
        case (md)
            MODE_PRESS: begin
                el = t - tap_t;
                if (tap_ok && el <= {16'h0000, dbl_tap_ms})
                    fl.double_tap = 1'b1;
                down = 1'b1;
                press_t = t;
                sx = int'(x); sy = int'(y);
                px = cx; py = cy;
                cx = int'(x); cy = int'(y);
            end
            MODE_RELEASE: begin
                el = t - press_t;
                d2 = dist_sq(int'(x), int'(y));
                down = 1'b0;
                cx = int'(x); cy = int'(y);
                px = int'(x); py = int'(y);
                if (!drg && !fl.hold && d2 < th2 && el < {16'h0000, hold_ms_c}) begin
                    fl.tap = 1'b1;
                    tap_t = t;
                    tap_ok = 1'b1;
                end
                if (d2 >= sm2 && el <= {16'h0000, swipe_ms_c}) begin
                    fl.swipe = 1'b1;
                    // A release in the same millisecond keeps the earlier velocity.
                    if (el != 0) begin
                        vx = ((longint'(x) - longint'(sx)) * longint'(VEL_SCALE)) /
                             longint'(el);
                        vy = ((longint'(y) - longint'(sy)) * longint'(VEL_SCALE)) /
                             longint'(el);
                    end
                end
                if (drg) begin
                    drg = 1'b0;
                    fl.drag_end = 1'b1;
                end
            end
            MODE_MOVE: begin
                px = cx; py = cy;
                cx = int'(x); cy = int'(y);
                fl.moved = 1'b1;
                check_drag_start();
            end
            default: begin
                if (!drg || !fl.moved) begin
                    px = cx; py = cy;
                end
                el = t - press_t;
                if (down && !drg && !fl.hold && el >= {16'h0000, hold_ms_c})
                    fl.hold = 1'b1;
                check_drag_start();
                res.tapped = fl.tap;
                res.double_tapped = fl.double_tap;
                res.hold_seen = fl.hold;
                res.drag_started = fl.drag_start;
                res.drag_ended = fl.drag_end;
                res.drag_active = drg;
                res.swipe_seen = fl.swipe;
                res.moved = fl.moved;
                res.swipe_vx = VEL_W'(clamp(vx, longint'(VEL_LIM)));
                res.swipe_vy = VEL_W'(clamp(vy, longint'(VEL_LIM)));
                res.delta_x = DELTA_W'(clamp(longint'(cx - px), longint'(DELTA_LIM)));
                res.delta_y = DELTA_W'(clamp(longint'(cy - py), longint'(DELTA_LIM)));
                fl = '0;
                vx = 0;
                vy = 0;
                has_res = 1'b1;
            end
        endcase
    endfunction

    function automatic logic signed [63:0] field_of(input result_t r, input int i);
        case (i)
            0: return 64'(r.tapped);
            1: return 64'(r.double_tapped);
            2: return 64'(r.hold_seen);
            3: return 64'(r.drag_started);
            4: return 64'(r.drag_ended);
            5: return 64'(r.drag_active);
            6: return 64'(r.swipe_seen);
            7: return 64'(r.moved);
            8: return 64'(r.swipe_vx);
            9: return 64'(r.swipe_vy);
            10: return 64'(r.delta_x);
            default: return 64'(r.delta_y);
        endcase
    endfunction

    // Offer one beat, with random idle cycles in front, and predict it once taken.
    task automatic send_item(input mode_t md, input logic [11:0] x, input logic [11:0] y,
                             input logic [31:0] t, input bit fixed = 1'b0,
                             input result_t want = '0);
        bit has_res;
        result_t res;
        while (!no_idle && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= md;
        s_axis_tdata <= {t, y, x};
        do @(posedge aclk); while (!s_axis_tready);
        recognise_event(md, x, y, t, has_res, res);
        if (has_res)
            frame_reports_q.push_back(fixed ? want : res);
        n_items++;
    endtask

    task automatic send_tick();
        now = now + $urandom_range(20);
        send_item(MODE_TICK, 12'($urandom), 12'($urandom), now);
    endtask

    // Stop offering beats until every frame report is in and the block has settled.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_reports_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_DOUBLE_TAP_MS: dbl_tap_ms = val;
            REG_HOLD_MS: hold_ms_c = val;
            REG_SWIPE_MAX_MS: swipe_ms_c = val;
            REG_SWIPE_MIN_DIST: swipe_dist_c = val[11:0];
            REG_DRAG_THRESHOLD: drag_th_c = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] dbl, input logic [15:0] hold,
                              input logic [15:0] swp_ms, input logic [15:0] swp_dist,
                              input logic [15:0] drag);
        write_reg(REG_DOUBLE_TAP_MS, dbl);
        write_reg(REG_HOLD_MS, hold);
        write_reg(REG_SWIPE_MAX_MS, swp_ms);
        write_reg(REG_SWIPE_MIN_DIST, swp_dist);
        write_reg(REG_DRAG_THRESHOLD, drag);
        cfg_we <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    // One pointer gesture of a random kind: tap, swipe, drag or hold.
    task automatic send_gesture();
        logic [11:0] bx, by, x, y;
        int kind, span;
        kind = $urandom_range(3);
        case ($urandom_range(19))
            0: now = $urandom;
            1: now = 32'hFFFF_FFFF - $urandom_range(400);
            default: now = now + $urandom_range(600);
        endcase
        bx = 12'($urandom);
        by = 12'($urandom);
        x = bx;
        y = by;
        span = (kind == 1) ? 600 : (kind == 2) ? 12 : 2;
        send_item(MODE_PRESS, bx, by, now);
        repeat ((kind == 0) ? $urandom_range(1) : $urandom_range(5, 1)) begin
            now = now + ((kind == 3) ? $urandom_range(300, 60) : $urandom_range(40));
            if (kind == 3) begin
                send_tick();
            end else begin
                x = bx + 12'($urandom_range(2 * span) - span);
                y = by + 12'($urandom_range(2 * span) - span);
                send_item(MODE_MOVE, x, y, now);
                if ($urandom_range(2) == 0)
                    send_tick();
            end
        end
        case (kind)
            1: now = now + $urandom_range(350);
            3: now = now + $urandom_range(900, 100);
            default: now = now + $urandom_range(120);
        endcase
        x = bx + 12'($urandom_range(2 * span) - span);
        y = by + 12'($urandom_range(2 * span) - span);
        send_item(MODE_RELEASE, x, y, now);
        // Leaving the tick out now and then lets a frame span two gestures.
        if ($urandom_range(3) != 0)
            send_tick();
    endtask

    task automatic send_noise();
        logic [31:0] t;
        t = ($urandom_range(3) == 0) ? $urandom : now + $urandom_range(50);
        send_item(mode_t'($urandom_range(3)), 12'($urandom), 12'($urandom), t);
    endtask

    // Directed stimulus table.
    typedef struct {
        mode_t       md;
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] t;
        bit          fixed;
        result_t     want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic void add_row(input mode_t md, input logic [11:0] x,
                                    input logic [11:0] y, input logic [31:0] t,
                                    input bit fixed = 1'b0, input result_t want = '0);
        dir_row_t r;
        r.md = md; r.x = x; r.y = y; r.t = t;
        r.fixed = fixed;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    function automatic result_t only_flags(input bit tap, input bit dtap, input bit hold);
        result_t r;
        r = '0;
        r.tapped = tap;
        r.double_tapped = dtap;
        r.hold_seen = hold;
        return r;
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    // Compare each result beat with the oldest frame report owed.
    always @(posedge aclk) begin
        result_t got, want;
        logic signed [63:0] g, w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (frame_reports_q.size() == 0) begin
                report_error("result beat with no tick waiting");
            end else begin
                want = frame_reports_q.pop_front();
                for (int i = 0; i < 12; i++) begin
                    g = field_of(got, i);
                    w = field_of(want, i);
                    if (g !== w)
                        report_error($sformatf("%s got %0d, expected %0d",
                                               field_names[i], g, w));
                end
                n_checked++;
                n_taps += int'(want.tapped);
                n_dtaps += int'(want.double_tapped);
                n_holds += int'(want.hold_seen);
                n_drags += int'(want.drag_started);
                n_swipes += int'(want.swipe_seen);
            end
        end
    end

    // Watchdog: too long without any beat or register write ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: timeout after %0d quiet cycles", quiet_cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int phase_items;
        bit paused;
        model_reset();
        now = '0;
        no_idle = 1'b0;
        rx_hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Tick straight after reset reports nothing.
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd0, 1'b1, only_flags(1'b0, 1'b0, 1'b0));
        // First tap: no tap recorded yet, so no double tap.
        add_row(MODE_PRESS, 12'd0, 12'd0, 32'd100);
        add_row(MODE_RELEASE, 12'd0, 12'd0, 32'd150);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd160, 1'b1, only_flags(1'b1, 1'b0, 1'b0));
        // Second tap inside the double tap window.
        add_row(MODE_PRESS, 12'd0, 12'd0, 32'd300);
        add_row(MODE_RELEASE, 12'd0, 12'd0, 32'd310);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd320, 1'b1, only_flags(1'b1, 1'b1, 1'b0));
        // Hold at the far corner.
        add_row(MODE_PRESS, 12'd4095, 12'd4095, 32'd1000);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd1600, 1'b1, only_flags(1'b0, 1'b0, 1'b1));
        // Drag across the full height, then end it by release.
        add_row(MODE_MOVE, 12'd4095, 12'd0, 32'd1700);
        add_row(MODE_TICK, 12'd4095, 12'd4095, 32'd1710);
        add_row(MODE_RELEASE, 12'd4095, 12'd0, 32'd1800);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd1810);
        // Fastest swipes in both directions.
        add_row(MODE_PRESS, 12'd0, 12'd0, 32'd2000);
        add_row(MODE_RELEASE, 12'd4095, 12'd4095, 32'd2001);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd2002);
        add_row(MODE_PRESS, 12'd4095, 12'd4095, 32'd2100);
        add_row(MODE_RELEASE, 12'd0, 12'd0, 32'd2101);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd2102);
        // Swipe with no time elapsed keeps the velocity untouched.
        add_row(MODE_PRESS, 12'd10, 12'd10, 32'd3000);
        add_row(MODE_RELEASE, 12'd200, 12'd10, 32'd3000);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd3001);
        // Release with the pointer already up.
        add_row(MODE_RELEASE, 12'd5, 12'd5, 32'd4000);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'd4001);
        // Tap across the wrap of the millisecond counter.
        add_row(MODE_PRESS, 12'd100, 12'd100, 32'hFFFF_FFF0);
        add_row(MODE_RELEASE, 12'd101, 12'd100, 32'h0000_0010);
        add_row(MODE_TICK, 12'd0, 12'd0, 32'hFFFF_FFFF);

        foreach (dir_rows[i])
            send_item(dir_rows[i].md, dir_rows[i].x, dir_rows[i].y, dir_rows[i].t,
                      dir_rows[i].fixed, dir_rows[i].want);
        drain_results();

        // Random gestures under a series of register settings.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_timing(DOUBLE_TAP_MS_RST, HOLD_MS_RST, SWIPE_MAX_MS_RST,
                              {4'h0, SWIPE_MIN_DIST_RST}, {4'h0, DRAG_THRESHOLD_RST});
                1: set_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: set_timing(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                default: set_timing(16'($urandom_range(800)), 16'($urandom_range(1000)),
                                    16'($urandom_range(500)),
                                    {4'($urandom), 12'($urandom_range(100))},
                                    {4'($urandom), 12'($urandom_range(10))});
            endcase
            no_idle = (p == 3);
            if (p == 4)
                rx_hold_req = 1'b1;
            phase_items = n_items;
            paused = 1'b0;
            while (n_items - phase_items < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15)
                    send_noise();
                else
                    send_gesture();
                // One pause half-way for every owed report to come back.
                if (p == 1 && !paused && n_items - phase_items >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_results();
                end
            end
            drain_results();
        end

        $display("tb: %0d beats sent, %0d frame reports checked, %0d register settings",
                 n_items, n_checked, n_settings);
        $display("tb: reports held %0d taps, %0d double taps, %0d holds, %0d drags, %0d swipes",
                 n_taps, n_dtaps, n_holds, n_drags, n_swipes);
        if (n_err == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[pointer_gesture_recognizer.f]
+incdir+hdl
hdl/pgr_pkg.sv
hdl/pgr_div.sv
hdl/pgr_datapath.sv
hdl/pgr_ctrl.sv
hdl/pointer_gesture_recognizer.sv
test/tb.sv
